// ===== rtl/c3f_pkg.sv =====
// Shared types, register codes and reset values for the 3x3 image filter.
package c3f_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned OUT_W      = 20;
  localparam int unsigned COEF_REG_W = 24;
  localparam int unsigned FW_W       = 11;
  localparam int unsigned FH_W       = 16;
  localparam int unsigned IDX_W      = 3;

  localparam logic [IDX_W-1:0] REG_COEF_TOP     = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF_MID     = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF_BOT     = 3'd2;
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd3;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  localparam logic [COEF_REG_W-1:0] COEF_TOP_RESET = 24'd16711681;
  localparam logic [COEF_REG_W-1:0] COEF_MID_RESET = 24'd16646146;
  localparam logic [COEF_REG_W-1:0] COEF_BOT_RESET = 24'd16711681;
  localparam logic [FW_W-1:0]       FW_RESET       = 11'd3;
  localparam logic [FH_W-1:0]       FH_RESET       = 16'd3;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel;
  } pix_req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic                    end_of_frame;
  } res_t;

  typedef struct packed {
    logic emit;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic last;
  } tap_ctl_t;

endpackage

// ===== rtl/c3f_line_ram.sv =====
// Two-row line buffer memory: one write port, one registered read port.
module c3f_line_ram #(
  parameter int DEPTH = 1024,
  parameter int DW    = 16
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/c3f_seq.sv =====
// Stream position counters and neighborhood edge masks.
module c3f_seq #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         restart,
  input  logic [c3f_pkg::FW_W-1:0]     frame_width,
  input  logic [c3f_pkg::FH_W-1:0]     frame_height,
  output logic [$clog2(MAX_WIDTH)-1:0] col,
  output c3f_pkg::tap_ctl_t            ctl
);
  import c3f_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  typedef enum logic [1:0] {ROW_FIRST, ROW_SECOND, ROW_REST} row_phase_t;

  row_phase_t      phase;
  logic [CW-1:0]   in_col;
  logic [CW-1:0]   out_col;
  logic [FH_W-1:0] out_row;
  logic [CW-1:0]   wm1;
  logic [FH_W-1:0] hm1;

  always_comb begin
    if (frame_width == '0) begin
      wm1 = '0;
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(frame_width - FW_W'(1));
    end
    hm1 = (frame_height == '0) ? '0 : frame_height - FH_W'(1);
  end

  assign col = (in_col > wm1) ? '0 : in_col;

  always_comb begin
    ctl.emit     = (phase == ROW_REST) || ((phase == ROW_SECOND) && (col != '0));
    ctl.top_ok   = (out_row != '0);
    ctl.bot_ok   = (out_row != hm1);
    ctl.left_ok  = (out_col != '0);
    ctl.right_ok = (out_col != wm1);
    ctl.last     = (out_row == hm1) && (out_col == wm1);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      phase   <= ROW_FIRST;
      in_col  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (accept) begin
      if (ctl.emit && ctl.last) begin
        phase   <= ROW_FIRST;
        in_col  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (col == wm1) begin
          in_col <= '0;
          unique case (phase)
            ROW_FIRST:  phase <= ROW_SECOND;
            ROW_SECOND: phase <= ROW_REST;
            ROW_REST:   phase <= ROW_REST;
            default:    phase <= ROW_FIRST;
          endcase
        end else begin
          in_col <= col + CW'(1);
        end
        if (ctl.emit) begin
          if (out_col == wm1) begin
            out_col <= '0;
            out_row <= out_row + FH_W'(1);
          end else begin
            out_col <= out_col + CW'(1);
          end
        end
      end
    end
  end

endmodule

// ===== rtl/c3f_mac.sv =====
// Masked 3x3 products, adder tree and output register.
module c3f_mac #(
  parameter int PIXEL_BITS = 8,
  parameter int COEF_BITS  = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [8:0][PIXEL_BITS-1:0]             taps,
  input  c3f_pkg::tap_ctl_t                      ctl,
  input  logic [2:0][c3f_pkg::COEF_REG_W-1:0]    coef_rows,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output c3f_pkg::res_t                          out_res
);
  import c3f_pkg::*;

  localparam int PW    = PIXEL_BITS + COEF_BITS + 1;
  localparam int SUM_W = PW + 4;
  localparam int EXT_W = (SUM_W > OUT_W) ? SUM_W : OUT_W;

  logic signed [PW-1:0]    prod      [9];
  logic signed [PW-1:0]    prod_next [9];
  logic                    s2_valid;
  logic                    s2_last;
  logic                    out_free;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [EXT_W-1:0] sum_ext;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !s2_valid || out_free;

  always_comb begin
    logic [3*COEF_BITS-1:0]        cw;
    logic signed [COEF_BITS-1:0]   cs;
    logic signed [PIXEL_BITS:0]    ps;
    logic                          keep;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        cw   = (3*COEF_BITS)'(coef_rows[r]);
        cs   = signed'(cw[c*COEF_BITS +: COEF_BITS]);
        ps   = signed'({1'b0, taps[r*3+c]});
        keep = (r != 0 || ctl.top_ok) && (r != 2 || ctl.bot_ok) &&
               (c != 0 || ctl.left_ok) && (c != 2 || ctl.right_ok);
        prod_next[r*3+c] = keep ? PW'(ps) * PW'(cs) : '0;
      end
    end
  end

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < 9; i++) begin
      sum_next = sum_next + SUM_W'(prod[i]);
    end
    sum_ext = EXT_W'(sum_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s2_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod    <= prod_next;
      s2_last <= ctl.last;
    end
    if (s2_valid && out_free) begin
      out_res.filtered     <= sum_ext[OUT_W-1:0];
      out_res.end_of_frame <= s2_last;
    end
  end

endmodule

// ===== rtl/conv3x3_image_filter_core.sv =====
// Top level of the zero-padded 3x3 image filter.
// Path to res: stage-1 registers, then the MAC product register, then the output register.
// Throughput: one request per clock while res is not stalled, set by the line RAM read and write-back per column.
// The first frame_width+1 requests of a frame produce no result.
// Reset (synchronous) clears counters, window and pipeline, restores register defaults;
// the line RAM is not cleared.
module conv3x3_image_filter_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8,
  parameter int COEF_BITS  = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pix_valid,
  output logic                           pix_ready,
  input  c3f_pkg::pix_req_t              pix,
  output logic                           res_valid,
  input  logic                           res_ready,
  output c3f_pkg::res_t                  res,
  input  logic                           wr_en,
  input  logic [c3f_pkg::IDX_W-1:0]      wr_index,
  input  logic [c3f_pkg::COEF_REG_W-1:0] wr_data
);
  import c3f_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = 2 * PIXEL_BITS;

  logic [2:0][COEF_REG_W-1:0] coef_rows;
  logic [FW_W-1:0]            frame_width;
  logic [FH_W-1:0]            frame_height;
  logic                       restart;

  logic                       accept;
  logic [CW-1:0]              seq_col;
  tap_ctl_t                   seq_ctl;

  logic                       s1_valid;
  logic                       s1_move;
  logic [CW-1:0]              s1_col;
  tap_ctl_t                   s1_ctl;
  logic [PIXEL_BITS-1:0]      s1_pix;
  logic                       fwd_hit;
  logic [EW-1:0]              fwd_entry;
  logic [EW-1:0]              rd_entry;
  logic [EW-1:0]              cur_entry;
  logic [EW-1:0]              wr_entry;
  logic [PIXEL_BITS-1:0]      above;
  logic [PIXEL_BITS-1:0]      above2;

  logic [2:0][2:0][PIXEL_BITS-1:0] win;
  logic [2:0][2:0][PIXEL_BITS-1:0] win_next;
  logic [8:0][PIXEL_BITS-1:0]      taps;
  logic                            mac_ready;

  assign restart = wr_en && (wr_index == REG_FRAME_WIDTH || wr_index == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_rows[0] <= COEF_TOP_RESET;
      coef_rows[1] <= COEF_MID_RESET;
      coef_rows[2] <= COEF_BOT_RESET;
      frame_width  <= FW_RESET;
      frame_height <= FH_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_COEF_TOP:     coef_rows[0] <= wr_data;
        REG_COEF_MID:     coef_rows[1] <= wr_data;
        REG_COEF_BOT:     coef_rows[2] <= wr_data;
        REG_FRAME_WIDTH:  frame_width  <= wr_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= wr_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_move   = s1_valid && (!s1_ctl.emit || mac_ready);
  assign pix_ready = !s1_valid || s1_move;
  assign accept    = pix_valid && pix_ready;

  c3f_seq #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .restart      (restart),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .col          (seq_col),
    .ctl          (seq_ctl)
  );

  c3f_line_ram #(
    .DEPTH(MAX_WIDTH),
    .DW   (EW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (seq_col),
    .rd_data (rd_entry),
    .wr_en   (s1_move),
    .wr_addr (s1_col),
    .wr_data (wr_entry)
  );

  assign cur_entry = fwd_hit ? fwd_entry : rd_entry;
  assign above     = cur_entry[PIXEL_BITS-1:0];
  assign above2    = cur_entry[EW-1:PIXEL_BITS];
  assign wr_entry  = {above, s1_pix};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (pix_ready) begin
        s1_valid <= pix_valid;
      end
      if (accept) begin
        fwd_hit <= s1_move && (s1_col == seq_col);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col    <= seq_col;
      s1_ctl    <= seq_ctl;
      s1_pix    <= (pix.kind == KIND_DRAIN) ? '0 : PIXEL_BITS'(pix.pixel);
      fwd_entry <= wr_entry;
    end
  end

  always_comb begin
    win_next[0][0] = above2;
    win_next[0][1] = above;
    win_next[0][2] = s1_pix;
    win_next[1]    = win[0];
    win_next[2]    = win[1];
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        taps[r*3+c] = win_next[2-c][r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_move) begin
      win <= win_next;
    end
  end

  c3f_mac #(
    .PIXEL_BITS(PIXEL_BITS),
    .COEF_BITS (COEF_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid && s1_ctl.emit),
    .in_ready  (mac_ready),
    .taps      (taps),
    .ctl       (s1_ctl),
    .coef_rows (coef_rows),
    .out_valid (res_valid),
    .out_ready (res_ready),
    .out_res   (res)
  );

endmodule

// ===== rtl/c3f_checker.sv =====
// Port-level assertions for the 3x3 image filter, bound to the top level.
module c3f_checker (
  input logic          clk,
  input logic          rst,
  input logic          pix_ready,
  input logic          res_valid,
  input logic          res_ready,
  input c3f_pkg::res_t res
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed or dropped while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> pix_ready)
    else $error("request refused with an empty output register");

  a_ready_when_taken: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |-> pix_ready)
    else $error("request refused while the result is taken");

endmodule

bind conv3x3_image_filter_core c3f_checker u_c3f_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_ready (pix_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
